// ----- hdl/ntbl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ntbl_pkg;

  // Width of the name field on both channels
  localparam int NAME_W = 64;
  // Width of the reported entry position
  localparam int IDX_W = 4;
  // Largest number of results a list request emits
  localparam int LIST_MAX = 16;

  typedef logic [NAME_W-1:0] name_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_LIST   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_CREATED  = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FOUND    = 3'd5,
    ST_EMPTY    = 3'd6
  } status_e;

  typedef struct packed {
    req_e  req_type;
    name_t name_key;
  } in_t;

  typedef struct packed {
    status_e status;
    name_t   entry_name;
    idx_t    entry_index;
    logic    last;
  } out_t;

endpackage

`default_nettype wire

// ----- hdl/ntbl_obuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ntbl_obuf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire ntbl_pkg::out_t item_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ntbl_pkg::out_t      out_item_o
);

  logic           valid_q, valid_d;
  ntbl_pkg::out_t item_q;

  // Free when empty or when the held item leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture a new item only when the slot frees up
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ----- hdl/name_table_insert_delete_search.sv -----
// Ordered name table with create, delete, search and list requests.
// Input channel: in_valid_i / in_stall_o carry one request item (req_type,
// name_key). Output channel: out_valid_o / out_stall_i carry result items
// (status, entry_name, entry_index, last). An item moves at a rising edge
// with valid high and stall low.
// One request is worked at a time; in_stall_o stays high until the request's
// last result has been loaded into the output register.
// With N stored entries: a search or create scans the table memory one
// entry per cycle through its single registered read port, stopping early
// on a match. A delete then moves each entry behind the deleted one down
// one place. A list reads each entry, then emits it, at most sixteen
// entries; it reads the next entry only once the output register has taken
// the current one.
// The output register holds one result; while it is full and out_stall_i is
// high the sequencer waits with the pending result and takes no new request.
// Reset clears the entry count and the sequencer; table contents are not
// cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module name_table_insert_delete_search #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ntbl_pkg::in_t  in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ntbl_pkg::out_t      out_item_o
);

  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW      = (IW > ntbl_pkg::IDX_W) ? IW : ntbl_pkg::IDX_W;
  localparam int ListMax = (ENTRIES < ntbl_pkg::LIST_MAX) ? ENTRIES : ntbl_pkg::LIST_MAX;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_RESOLVE = 7'b0000100,
    S_SHIFT   = 7'b0001000,
    S_EMIT    = 7'b0010000,
    S_LRD     = 7'b0100000,
    S_LEMIT   = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         rd_idx_q, rd_idx_d;
  logic [IW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                  pend_q, pend_d;
  logic                  found_q, found_d;
  logic [IW-1:0]         pos_q, pos_d;
  ntbl_pkg::req_e        req_q, req_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  ntbl_pkg::status_e     res_status_q, res_status_d;
  logic [IW-1:0]         res_idx_q, res_idx_d;

  // Table memory: one write and one registered read per cycle
  logic [KEY_BITS-1:0]   mem [ENTRIES];
  logic [KEY_BITS-1:0]   rdata_q;
  logic                  rd_en;
  logic [IW-1:0]         raddr;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [KEY_BITS-1:0]   wdata;

  logic                  in_accept;
  logic                  rd_more;
  logic [CW-1:0]         list_n;
  logic                  list_last;
  logic [PW-1:0]         res_idx_ext;
  logic [PW-1:0]         list_idx_ext;

  logic                  ob_load;
  logic                  ob_ready;
  ntbl_pkg::out_t        ob_item;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign rd_more    = (rd_idx_q < count_q);
  assign raddr      = rd_idx_q[IW-1:0];

  assign list_n    = (count_q > CW'(ListMax)) ? CW'(ListMax) : count_q;
  assign list_last = ((rd_idx_q + CW'(1)) == list_n);

  assign res_idx_ext  = PW'(res_idx_q);
  assign list_idx_ext = PW'(rd_idx_q[IW-1:0]);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    pend_d       = pend_q;
    found_d      = found_q;
    pos_d        = pos_q;
    req_d        = req_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    rd_en        = 1'b0;
    we           = 1'b0;
    waddr        = count_q[IW-1:0];
    wdata        = key_q;
    ob_load      = 1'b0;
    ob_item      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d    = in_item_i.req_type;
          key_d    = in_item_i.name_key[KEY_BITS-1:0];
          rd_idx_d = '0;
          pend_d   = 1'b0;
          if (in_item_i.req_type == ntbl_pkg::REQ_LIST) begin
            if (count_q == '0) begin
              res_status_d = ntbl_pkg::ST_EMPTY;
              res_idx_d    = '0;
              state_d      = S_EMIT;
            end else begin
              state_d = S_LRD;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // Read one entry per cycle, compare the one read last cycle
      S_SCAN: begin
        rd_en     = rd_more;
        pend_d    = rd_more;
        cmp_idx_d = raddr;
        if (rd_more) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (pend_q && (rdata_q == key_q)) begin
          found_d = 1'b1;
          pos_d   = cmp_idx_q;
          state_d = S_RESOLVE;
        end else if (!pend_q && !rd_more) begin
          found_d = 1'b0;
          state_d = S_RESOLVE;
        end
      end

      S_RESOLVE: begin
        state_d   = S_EMIT;
        res_idx_d = found_q ? pos_q : '0;
        case (req_q)
          ntbl_pkg::REQ_CREATE: begin
            if (found_q) begin
              res_status_d = ntbl_pkg::ST_DUP;
            end else if (count_q == CW'(ENTRIES)) begin
              res_status_d = ntbl_pkg::ST_FULL;
            end else begin
              we           = 1'b1;
              res_status_d = ntbl_pkg::ST_CREATED;
              res_idx_d    = count_q[IW-1:0];
              count_d      = count_q + CW'(1);
            end
          end
          ntbl_pkg::REQ_DELETE: begin
            if (found_q) begin
              res_status_d = ntbl_pkg::ST_DELETED;
              rd_idx_d     = CW'(pos_q) + CW'(1);
              pend_d       = 1'b0;
              state_d      = S_SHIFT;
            end else begin
              res_status_d = ntbl_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            res_status_d = found_q ? ntbl_pkg::ST_FOUND : ntbl_pkg::ST_NOTFOUND;
          end
        endcase
      end

      // Move later entries down one place: read i, then write i - 1
      S_SHIFT: begin
        rd_en     = rd_more;
        pend_d    = rd_more;
        cmp_idx_d = raddr - IW'(1);
        if (rd_more) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        we    = pend_q;
        waddr = cmp_idx_q;
        wdata = rdata_q;
        if (!pend_q && !rd_more) begin
          count_d = count_q - CW'(1);
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        ob_load             = 1'b1;
        ob_item.status      = res_status_q;
        ob_item.entry_index = res_idx_ext[ntbl_pkg::IDX_W-1:0];
        ob_item.last        = 1'b1;
        if (ob_ready) begin
          state_d = S_IDLE;
        end
      end

      S_LRD: begin
        rd_en   = 1'b1;
        state_d = S_LEMIT;
      end

      // Emit the listed entry, then read the next or finish
      S_LEMIT: begin
        ob_load             = 1'b1;
        ob_item.status      = ntbl_pkg::ST_FOUND;
        ob_item.entry_name  = ntbl_pkg::name_t'(rdata_q);
        ob_item.entry_index = list_idx_ext[ntbl_pkg::IDX_W-1:0];
        ob_item.last        = list_last;
        if (ob_ready) begin
          if (list_last) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + CW'(1);
            state_d  = S_LRD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    found_q      <= found_d;
    pos_q        <= pos_d;
    req_q        <= req_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
  end

  // Table memory access
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  ntbl_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ob_load),
    .item_i      (ob_item),
    .ready_o     (ob_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/name_table_insert_delete_search_tb.sv -----
`timescale 1ns / 1ps

module name_table_insert_delete_search_tb;

  localparam int TABLE_DEPTH  = 16;
  localparam int POOL_SIZE    = 24;
  localparam int SEGMENTS     = 10;
  localparam int SEG_ITEMS    = 50;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int TAIL_CYCLES  = 64;
  localparam int STUCK_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    ntbl_pkg::in_t item;
    bit            drain_first;
  } pend_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  ntbl_pkg::in_t   in_item   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  ntbl_pkg::out_t  out_item;

  // Shadow copy of the name table
  ntbl_pkg::name_t table_names [TABLE_DEPTH];
  int              table_count = 0;

  pend_t           pending [$];
  ntbl_pkg::out_t  owed_results [$];
  ntbl_pkg::name_t key_pool [POOL_SIZE];

  int err_cnt      = 0;
  int results_seen = 0;
  int stuck        = 0;
  int gap_left     = 0;
  int burst_left   = 1;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int stall_mode   = 0;
  int window_left  = 0;

  name_table_insert_delete_search dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic ntbl_pkg::out_t make_result(ntbl_pkg::status_e st,
                                                 ntbl_pkg::name_t nm, int idx,
                                                 bit fin);
    ntbl_pkg::out_t r;
    r.status      = st;
    r.entry_name  = nm;
    r.entry_index = ntbl_pkg::idx_t'(idx);
    r.last        = fin;
    return r;
  endfunction

  function automatic int find_name(ntbl_pkg::name_t key);
    for (int i = 0; i < table_count; i++) begin
      if (table_names[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and queue the results it owes
  function automatic void predict_table_op(ntbl_pkg::in_t req);
    int pos;
    pos = find_name(req.name_key);
    case (req.req_type)
      ntbl_pkg::REQ_CREATE: begin
        if (pos >= 0) begin
          owed_results.push_back(make_result(ntbl_pkg::ST_DUP, '0, pos, 1'b1));
        end else if (table_count >= TABLE_DEPTH) begin
          owed_results.push_back(make_result(ntbl_pkg::ST_FULL, '0, 0, 1'b1));
        end else begin
          table_names[table_count] = req.name_key;
          owed_results.push_back(make_result(ntbl_pkg::ST_CREATED, '0, table_count,
                                             1'b1));
          table_count++;
        end
      end
      ntbl_pkg::REQ_DELETE: begin
        if (pos < 0) begin
          owed_results.push_back(make_result(ntbl_pkg::ST_NOTFOUND, '0, 0, 1'b1));
        end else begin
          for (int i = pos; i + 1 < table_count; i++) table_names[i] = table_names[i + 1];
          table_count--;
          owed_results.push_back(make_result(ntbl_pkg::ST_DELETED, '0, pos, 1'b1));
        end
      end
      ntbl_pkg::REQ_SEARCH: begin
        if (pos < 0) owed_results.push_back(make_result(ntbl_pkg::ST_NOTFOUND, '0, 0, 1'b1));
        else owed_results.push_back(make_result(ntbl_pkg::ST_FOUND, '0, pos, 1'b1));
      end
      default: begin
        if (table_count == 0) begin
          owed_results.push_back(make_result(ntbl_pkg::ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < table_count; i++) begin
            owed_results.push_back(make_result(ntbl_pkg::ST_FOUND, table_names[i], i,
                                               i + 1 == table_count));
          end
        end
      end
    endcase
  endfunction

  function automatic void add_request(ntbl_pkg::req_e op, ntbl_pkg::name_t key,
                                      bit drain = 1'b0);
    pend_t p;
    p.item.req_type = op;
    p.item.name_key = key;
    p.drain_first   = drain;
    pending.push_back(p);
  endfunction

  // Compare one accepted result with the oldest owed one
  function automatic void check_result(ntbl_pkg::out_t got);
    ntbl_pkg::out_t want;
    results_seen++;
    if (owed_results.size() == 0) begin
      if (err_cnt < REPORT_MAX)
        $display("unexpected result: status=%0d name=%h index=%0d last=%0b",
                 got.status, got.entry_name, got.entry_index, got.last);
      err_cnt++;
    end else begin
      want = owed_results.pop_front();
      if (got.status !== want.status || got.entry_name !== want.entry_name ||
          got.entry_index !== want.entry_index || got.last !== want.last) begin
        if (err_cnt < REPORT_MAX)
          $display({"mismatch: exp status=%0d name=%h index=%0d last=%0b, ",
                    "got status=%0d name=%h index=%0d last=%0b"},
                   want.status, want.entry_name, want.entry_index, want.last,
                   got.status, got.entry_name, got.entry_index, got.last);
        err_cnt++;
      end
    end
  endfunction

  // Drive request items in bursts; optionally hold until all results are back
  always @(posedge clk or negedge rst_n) begin : drive_p
    pend_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) predict_table_op(in_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0 && (!pending[0].drain_first ||
                     (owed_results.size() == 0 && !(out_valid && !out_stall)))) begin
          nxt = pending.pop_front();
          in_item  <= nxt.item;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check results and stall the output on a pattern of its own
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (window_left == 0) begin
          stall_mode  = $urandom_range(0, 2);
          window_left = $urandom_range(8, 60);
        end else begin
          window_left--;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Count cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
  end

  initial begin
    int              r;
    bit              fill_phase;
    bit              timed_out;
    ntbl_pkg::name_t key;
    ntbl_pkg::req_e  op;

    timed_out   = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    // Directed: empty table, zero and all-ones names, duplicate, full, list
    add_request(ntbl_pkg::REQ_LIST, '0);
    add_request(ntbl_pkg::REQ_SEARCH, key_pool[0]);
    add_request(ntbl_pkg::REQ_DELETE, key_pool[0]);
    add_request(ntbl_pkg::REQ_CREATE, key_pool[0]);
    add_request(ntbl_pkg::REQ_CREATE, key_pool[1]);
    add_request(ntbl_pkg::REQ_CREATE, key_pool[0]);
    add_request(ntbl_pkg::REQ_SEARCH, key_pool[1]);
    for (int i = 2; i < TABLE_DEPTH; i++) add_request(ntbl_pkg::REQ_CREATE, key_pool[i]);
    add_request(ntbl_pkg::REQ_CREATE, key_pool[TABLE_DEPTH]);
    add_request(ntbl_pkg::REQ_LIST, '1);
    add_request(ntbl_pkg::REQ_DELETE, key_pool[0]);
    add_request(ntbl_pkg::REQ_DELETE, key_pool[TABLE_DEPTH - 1]);
    add_request(ntbl_pkg::REQ_LIST, '0);

    // Random: alternate fill-heavy and drain-heavy segments over a small name pool
    for (int s = 0; s < SEGMENTS; s++) begin
      fill_phase = (s % 2 == 0);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < (fill_phase ? 55 : 20)) op = ntbl_pkg::REQ_CREATE;
        else if (r < 70) op = ntbl_pkg::REQ_DELETE;
        else if (r < 85) op = ntbl_pkg::REQ_SEARCH;
        else op = ntbl_pkg::REQ_LIST;
        if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
        else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        add_request(op, key, n == 0 && (s == 0 || s == SEGMENTS / 2));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all items to be taken and all results to come back
    while (!timed_out && (pending.size() > 0 || in_valid || owed_results.size() > 0)) begin
      @(negedge clk);
      if (stuck >= STUCK_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);
    err_cnt += owed_results.size();

    if (!timed_out && err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
